// ===== hw/rtl/bts_pkg.sv =====
// Shared types and constants of the bilinear texture sampler.
package bts_pkg;

	// Color channel and texel word layout (red high, blue low)
	localparam int CHAN_BITS  = 8;
	localparam int TEXEL_BITS = 3 * CHAN_BITS;
	localparam int RED_LSB    = 2 * CHAN_BITS;
	localparam int GREEN_LSB  = CHAN_BITS;
	localparam int BLUE_LSB   = 0;

	// Configuration port
	localparam int CFG_INDEX_BITS = 2;
	localparam int LOG2_BITS      = 3;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_WIDTH_LOG2  = 2'd0,
		REG_HEIGHT_LOG2 = 2'd1
	} cfg_reg_t;

	// Input word kind
	typedef enum logic {
		MODE_WRITE  = 1'b0,
		MODE_SAMPLE = 1'b1
	} mode_t;

endpackage

// ===== hw/rtl/bts_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module bts_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 16384
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, data held while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hw/rtl/bts_channel_filter.sv =====
// One color channel of the bilinear blend: horizontal lerp, vertical lerp, rounding.
module bts_channel_filter #(
	parameter int FRAC_BITS = 16
) (
	input  logic                           clk,
	input  logic                           en,
	input  logic [bts_pkg::CHAN_BITS-1:0]  t00,
	input  logic [bts_pkg::CHAN_BITS-1:0]  t01,
	input  logic [bts_pkg::CHAN_BITS-1:0]  t10,
	input  logic [bts_pkg::CHAN_BITS-1:0]  t11,
	input  logic [FRAC_BITS-1:0]           fx,
	input  logic [FRAC_BITS-1:0]           fy,
	output logic [bts_pkg::CHAN_BITS-1:0]  result
);

	import bts_pkg::*;

	localparam int F  = FRAC_BITS;
	localparam int HW = CHAN_BITS + F;   // horizontal blend, exact, scale 2^F
	localparam int VW = HW + F + 2;      // vertical terms, signed

	// stage 3: h = a*2^F + (b - a)*fx, per row
	logic signed [CHAN_BITS:0]     d0, d1;
	logic signed [CHAN_BITS+F+1:0] m0, m1, s0, s1;
	logic [HW-1:0]                 h0_s3, h1_s3;
	logic [F-1:0]                  fy_s3;

	assign d0 = $signed({1'b0, t01}) - $signed({1'b0, t00});
	assign d1 = $signed({1'b0, t11}) - $signed({1'b0, t10});
	assign m0 = d0 * $signed({1'b0, fx});
	assign m1 = d1 * $signed({1'b0, fx});
	assign s0 = $signed({2'b00, t00, {F{1'b0}}}) + m0;
	assign s1 = $signed({2'b00, t10, {F{1'b0}}}) + m1;

	always_ff @(posedge clk) begin
		if (en) begin
			h0_s3 <= s0[HW-1:0];
			h1_s3 <= s1[HW-1:0];
			fy_s3 <= fy;
		end
	end

	// stage 4: (h1 - h0)*fy
	logic signed [HW:0]   dh;
	logic signed [VW-1:0] mv;
	logic signed [VW-1:0] prod_s4;
	logic [HW-1:0]        h0_s4;

	assign dh = $signed({1'b0, h1_s3}) - $signed({1'b0, h0_s3});
	assign mv = dh * $signed({1'b0, fy_s3});

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s4 <= mv;
			h0_s4   <= h0_s3;
		end
	end

	// stage 5: h0*2^F + product, round half up, drop 2F fraction bits
	logic signed [VW-1:0] rnd;
	logic signed [VW-1:0] sum;
	logic [CHAN_BITS-1:0] result_s5;

	assign rnd = $signed({{(CHAN_BITS+2){1'b0}}, 1'b1, {(2*F-1){1'b0}}});
	assign sum = $signed({2'b00, h0_s4, {F{1'b0}}}) + prod_s4 + rnd;

	always_ff @(posedge clk) begin
		if (en) begin
			result_s5 <= sum[2*F +: CHAN_BITS];
		end
	end

	assign result = result_s5;

endmodule

// ===== hw/rtl/bilinear_texture_sampler_top.sv =====
// Top level of the bilinear texture sampler: texel store, address stage, blend pipeline.
// A sample word loads s1 at the edge that accepts it, then passes s2 to s5 and the output
// register to out_valid, and a stall can hold it; write words make no output word.
// Throughput: one word per cycle unless stalled, set by four copies of the texel store each
// read once a cycle. Stalls come only when both the output register and skid stage are full.
// Reset: asynchronous, clears valid bits and sets width_log2 and height_log2 to 7 (clamped to
// MAX_DIM_LOG2); the texel store is not cleared and holds no data until written.
module bilinear_texture_sampler_top #(
	parameter int MAX_DIM_LOG2    = 7,
	parameter int COORD_FRAC_BITS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [bts_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [bts_pkg::LOG2_BITS-1:0]      cfg_data,
	// input words
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               mode,
	input  logic [13:0]                        texel_address,
	input  logic [bts_pkg::CHAN_BITS-1:0]      texel_red,
	input  logic [bts_pkg::CHAN_BITS-1:0]      texel_green,
	input  logic [bts_pkg::CHAN_BITS-1:0]      texel_blue,
	input  logic signed [23:0]                 coord_u,
	input  logic signed [23:0]                 coord_v,
	// output words
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [bts_pkg::CHAN_BITS-1:0]      out_red,
	output logic [bts_pkg::CHAN_BITS-1:0]      out_green,
	output logic [bts_pkg::CHAN_BITS-1:0]      out_blue
);

	import bts_pkg::*;

	localparam int M          = MAX_DIM_LOG2;
	localparam int F          = COORD_FRAC_BITS;
	localparam int ADDR_BITS  = 2 * M;
	localparam int DEPTH      = 1 << ADDR_BITS;
	localparam int LOG2_RESET = (M < 7) ? M : 7;

	// ---------------------------------------------------------------
	// configuration registers, clamped to MAX_DIM_LOG2
	// ---------------------------------------------------------------
	logic [LOG2_BITS-1:0] width_log2_q, height_log2_q;
	logic [LOG2_BITS-1:0] cfg_clamped;

	assign cfg_ready   = 1'b1;
	assign cfg_clamped = (int'(cfg_data) > M) ? LOG2_BITS'(M) : cfg_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_log2_q  <= LOG2_BITS'(LOG2_RESET);
			height_log2_q <= LOG2_BITS'(LOG2_RESET);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_WIDTH_LOG2:  width_log2_q  <= cfg_clamped;
				REG_HEIGHT_LOG2: height_log2_q <= cfg_clamped;
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------
	// pipeline enable: advance unless the output skid stage is full
	// ---------------------------------------------------------------
	logic pipe_en;
	logic skid_v_q;

	assign pipe_en  = !skid_v_q;
	assign in_ready = pipe_en;

	// ---------------------------------------------------------------
	// stage 1: wrap coordinates, scale, pick texel columns and rows
	// ---------------------------------------------------------------
	logic [F+M-1:0]   xs, ys;
	logic [M-1:0]     wmask, hmask;
	logic [M-1:0]     col0, col1, row0, row1;
	logic [ADDR_BITS+13:0] waddr_ext;

	assign xs    = {{M{1'b0}}, coord_u[F-1:0]} << width_log2_q;
	assign ys    = {{M{1'b0}}, coord_v[F-1:0]} << height_log2_q;
	assign wmask = ~({M{1'b1}} << width_log2_q);
	assign hmask = ~({M{1'b1}} << height_log2_q);
	assign col0  = xs[F +: M] & wmask;
	assign row0  = ys[F +: M] & hmask;
	assign col1  = (col0 + M'(1)) & wmask;
	assign row1  = (row0 + M'(1)) & hmask;
	assign waddr_ext = {{ADDR_BITS{1'b0}}, texel_address};

	logic                  v_s1, sample_s1;
	logic [M-1:0]          col0_s1, col1_s1, row0_s1, row1_s1;
	logic [F-1:0]          fx_s1, fy_s1;
	logic [ADDR_BITS-1:0]  waddr_s1;
	logic [TEXEL_BITS-1:0] wdata_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (pipe_en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			sample_s1 <= (mode == MODE_SAMPLE);
			col0_s1   <= col0;
			col1_s1   <= col1;
			row0_s1   <= row0;
			row1_s1   <= row1;
			fx_s1     <= xs[F-1:0];
			fy_s1     <= ys[F-1:0];
			waddr_s1  <= waddr_ext[ADDR_BITS-1:0];
			wdata_s1  <= {texel_red, texel_green, texel_blue};
		end
	end

	// ---------------------------------------------------------------
	// stage 2: texel store, four copies so all neighbors read at once
	// ---------------------------------------------------------------
	logic [ADDR_BITS-1:0]  ra00, ra01, ra10, ra11;
	logic                  ram_we;
	logic [TEXEL_BITS-1:0] t00, t01, t10, t11;

	assign ra00 = ({{M{1'b0}}, row0_s1} << width_log2_q) | ADDR_BITS'(col0_s1);
	assign ra01 = ({{M{1'b0}}, row0_s1} << width_log2_q) | ADDR_BITS'(col1_s1);
	assign ra10 = ({{M{1'b0}}, row1_s1} << width_log2_q) | ADDR_BITS'(col0_s1);
	assign ra11 = ({{M{1'b0}}, row1_s1} << width_log2_q) | ADDR_BITS'(col1_s1);
	assign ram_we = pipe_en && v_s1 && !sample_s1;

	bts_ram #(.WIDTH(TEXEL_BITS), .DEPTH(DEPTH)) u_ram00 (
		.clk(clk), .we(ram_we), .waddr(waddr_s1), .wdata(wdata_s1),
		.re(pipe_en), .raddr(ra00), .rdata(t00)
	);
	bts_ram #(.WIDTH(TEXEL_BITS), .DEPTH(DEPTH)) u_ram01 (
		.clk(clk), .we(ram_we), .waddr(waddr_s1), .wdata(wdata_s1),
		.re(pipe_en), .raddr(ra01), .rdata(t01)
	);
	bts_ram #(.WIDTH(TEXEL_BITS), .DEPTH(DEPTH)) u_ram10 (
		.clk(clk), .we(ram_we), .waddr(waddr_s1), .wdata(wdata_s1),
		.re(pipe_en), .raddr(ra10), .rdata(t10)
	);
	bts_ram #(.WIDTH(TEXEL_BITS), .DEPTH(DEPTH)) u_ram11 (
		.clk(clk), .we(ram_we), .waddr(waddr_s1), .wdata(wdata_s1),
		.re(pipe_en), .raddr(ra11), .rdata(t11)
	);

	logic         v_s2;
	logic [F-1:0] fx_s2, fy_s2;

	// only sample words continue past the store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (pipe_en) begin
			v_s2 <= v_s1 && sample_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			fx_s2 <= fx_s1;
			fy_s2 <= fy_s1;
		end
	end

	// ---------------------------------------------------------------
	// stages 3 to 5: per-channel blend
	// ---------------------------------------------------------------
	logic [CHAN_BITS-1:0] red_s5, green_s5, blue_s5;

	bts_channel_filter #(.FRAC_BITS(F)) u_red (
		.clk(clk), .en(pipe_en),
		.t00(t00[RED_LSB +: CHAN_BITS]), .t01(t01[RED_LSB +: CHAN_BITS]),
		.t10(t10[RED_LSB +: CHAN_BITS]), .t11(t11[RED_LSB +: CHAN_BITS]),
		.fx(fx_s2), .fy(fy_s2), .result(red_s5)
	);
	bts_channel_filter #(.FRAC_BITS(F)) u_green (
		.clk(clk), .en(pipe_en),
		.t00(t00[GREEN_LSB +: CHAN_BITS]), .t01(t01[GREEN_LSB +: CHAN_BITS]),
		.t10(t10[GREEN_LSB +: CHAN_BITS]), .t11(t11[GREEN_LSB +: CHAN_BITS]),
		.fx(fx_s2), .fy(fy_s2), .result(green_s5)
	);
	bts_channel_filter #(.FRAC_BITS(F)) u_blue (
		.clk(clk), .en(pipe_en),
		.t00(t00[BLUE_LSB +: CHAN_BITS]), .t01(t01[BLUE_LSB +: CHAN_BITS]),
		.t10(t10[BLUE_LSB +: CHAN_BITS]), .t11(t11[BLUE_LSB +: CHAN_BITS]),
		.fx(fx_s2), .fy(fy_s2), .result(blue_s5)
	);

	// valid bits follow the channel pipelines
	logic v_s3, v_s4, v_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (pipe_en) begin
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// ---------------------------------------------------------------
	// output register with skid stage
	// ---------------------------------------------------------------
	logic                   out_v_q;
	logic [TEXEL_BITS-1:0]  out_word_q, skid_word_q;
	logic                   pipe_out;

	assign pipe_out = v_s5 && pipe_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || out_ready) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= pipe_out;
			end
		end else if (pipe_out) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || out_ready) begin
			if (skid_v_q) begin
				out_word_q <= skid_word_q;
			end else if (pipe_out) begin
				out_word_q <= {red_s5, green_s5, blue_s5};
			end
		end else if (pipe_out) begin
			skid_word_q <= {red_s5, green_s5, blue_s5};
		end
	end

	assign out_valid = out_v_q;
	assign out_red   = out_word_q[RED_LSB +: CHAN_BITS];
	assign out_green = out_word_q[GREEN_LSB +: CHAN_BITS];
	assign out_blue  = out_word_q[BLUE_LSB +: CHAN_BITS];

	// ---------------------------------------------------------------
	// assertions
	// ---------------------------------------------------------------
	// skid stage only fills behind a waiting output word
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid stage full without output word");

	// a texel write never reaches the blend pipeline
	a_write_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(pipe_en && v_s1 && !sample_s1) |=> !v_s2)
		else $error("write word entered blend pipeline");

	// stalled pipeline keeps its s2 and s5 valid bits
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!pipe_en |=> (v_s5 == $past(v_s5)) && (v_s2 == $past(v_s2)))
		else $error("pipeline moved while stalled");

	// in-range width write lands unchanged
	a_cfg_width: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_valid && cfg_index == REG_WIDTH_LOG2 && int'(cfg_data) <= M)
		|=> width_log2_q == $past(cfg_data))
		else $error("width_log2 write lost");

endmodule
